// File: design/bgelu_pkg.sv
`default_nettype none
package bgelu_pkg;

  localparam int DATA_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;

  // internal fixed-point formats
  localparam int IQ = 24;
  localparam int EQ = 30;
  localparam int TAYLOR_TERMS = 12;

  localparam int YQ_W  = 29;
  localparam int Y2_W  = 32;
  localparam int Y3_W  = 35;
  localparam int IN_W  = 31;
  localparam int U_W   = 31;
  localparam int A_W   = 28;
  localparam int V_W   = 35;
  localparam int R_W   = 30;
  localparam int P_W   = 31;
  localparam int K_W   = 5;
  localparam int K_MAX = 23;
  localparam int DEN_W = 32;
  localparam int Q_W   = 25;
  localparam int DVD_W = 56;

  localparam logic signed [21:0] C_CUBIC   = 22'sd750193;
  localparam logic signed [24:0] C_SQRT2PI = 25'sd13386282;
  localparam logic [63:0]        LN2_Q30   = 64'd744261118;
  localparam logic [P_W-1:0]     ONE_P     = P_W'(64'd1 << EQ);
  localparam logic signed [U_W-1:0] U_SAT  = U_W'(64'sd1 <<< (IQ + 3));

  // pipeline depths
  localparam int LAT_FRONT = 7;
  localparam int LAT_STEP  = 3;
  localparam int LAT_EXP   = LAT_STEP * TAYLOR_TERMS;
  localparam int LAT_DIV   = Q_W;
  localparam int SIDE_DLY  = LAT_FRONT - 1 + LAT_EXP + 1 + LAT_DIV;
  localparam int LAT_TOTAL = SIDE_DLY + 1 + 2;

  // register index decode
  localparam logic REG_IDX_GELU = 1'b0;

  typedef struct packed {
    logic [K_W-1:0] k;
    logic           neg;
    logic           tsat;
  } tside_t;

  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [V_W-1:0] ln2_mul(input logic [K_W-1:0] k);
    return V_W'(64'(k) * LN2_Q30);
  endfunction

endpackage
`default_nettype wire

// File: design/bias_add_gelu_activation.sv
`default_nettype none
// Throughput: one item per cycle; busy is never raised.
// The depth comes from the 12-step series for exp (3 stages each) and
// the 25-stage restoring divider for tanh.
// Reset (rst_n low, synchronous) drops all items in flight and sets gelu_enable to 1.
// The receiver cannot stall: every result shows for exactly one cycle.
module bias_add_gelu_activation #(
  parameter int DATA_WIDTH = bgelu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = bgelu_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic signed [DATA_WIDTH-1:0] in_bias,
  input  logic                         in_last,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic                         out_last,
  output logic                         out_saturated,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bgelu_pkg::*;

  localparam int ADDR_W = 3;
  localparam int SH_Q   = IQ - FRAC_BITS;
  localparam int FIN_SH = 2 * IQ + 1 - FRAC_BITS;
  localparam logic signed [63:0] LIM  = 64'sd8 <<< FRAC_BITS;
  localparam logic signed [63:0] MAXV = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] MINV = -MAXV - 64'sd1;
  localparam int PW = YQ_W + 27;

  logic gelu_en_r;
  logic in_vld;

  logic signed [DATA_WIDTH-1:0] y1;
  logic sat1, last1;

  logic [R_W-1:0]  ch_r    [TAYLOR_TERMS+1];
  logic [P_W-1:0]  ch_p    [TAYLOR_TERMS+1];
  tside_t          ch_side [TAYLOR_TERMS+1];
  logic [TAYLOR_TERMS:0] ch_vld;

  logic [DATA_WIDTH+1:0] dly_r [SIDE_DLY];

  logic [P_W-1:0]   e, num;
  logic [DEN_W-1:0] den, den_r;
  logic [DVD_W-1:0] dvd, dvd_r;
  logic             neg_e_r, tsat_e_r, vld_e_r;

  logic             vld_d, neg_d, tsat_d;
  logic [Q_W-1:0]   q_d;

  logic signed [DATA_WIDTH-1:0] y_d, y_f_r;
  logic             sat_d, last_d, sat_f_r, last_f_r, vld_f_r;
  logic signed [YQ_W-1:0] yq_f;
  logic [Q_W-1:0]   tmag;
  logic [Q_W:0]     onep;
  logic signed [PW-1:0] prod, prod_r;

  logic signed [63:0] y64, res, sel;
  logic out_valid_r, out_last_r, out_sat_r;
  logic signed [DATA_WIDTH-1:0] out_value_r;

  assign busy   = 1'b0;
  assign in_vld = start && !busy;
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_IDX_GELU) ? {31'b0, gelu_en_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gelu_en_r <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1] == REG_IDX_GELU) begin
      gelu_en_r <= pwdata[0];
    end
  end

  bgelu_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_vld),
    .x_i    (in_value),
    .b_i    (in_bias),
    .last_i (in_last),
    .y_o    (y1),
    .sat_o  (sat1),
    .last_o (last1),
    .vld_o  (ch_vld[0]),
    .r_o    (ch_r[0]),
    .side_o (ch_side[0])
  );

  assign ch_p[0] = ONE_P;

  // Horner chain, highest term first
  for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_exp
    bgelu_exp_step #(
      .N (TAYLOR_TERMS - i)
    ) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (ch_vld[i]),
      .r_i    (ch_r[i]),
      .p_i    (ch_p[i]),
      .side_i (ch_side[i]),
      .vld_o  (ch_vld[i+1]),
      .r_o    (ch_r[i+1]),
      .p_o    (ch_p[i+1]),
      .side_o (ch_side[i+1])
    );
  end

  // hold y, flag and marker alongside the tanh path
  always_ff @(posedge clk) begin
    dly_r[0] <= {last1, sat1, y1};
    for (int i = 1; i < SIDE_DLY; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  always_comb begin
    e   = ch_p[TAYLOR_TERMS] >> ch_side[TAYLOR_TERMS].k;
    num = ONE_P - e;
    den = DEN_W'(ONE_P) + DEN_W'(e);
    dvd = (DVD_W'(num) << IQ) + DVD_W'(den >> 1);
  end

  always_ff @(posedge clk) begin
    dvd_r    <= dvd;
    den_r    <= den;
    neg_e_r  <= ch_side[TAYLOR_TERMS].neg;
    tsat_e_r <= ch_side[TAYLOR_TERMS].tsat;
  end

  bgelu_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld_e_r),
    .dvd_i  (dvd_r),
    .den_i  (den_r),
    .neg_i  (neg_e_r),
    .tsat_i (tsat_e_r),
    .vld_o  (vld_d),
    .q_o    (q_d),
    .neg_o  (neg_d),
    .tsat_o (tsat_d)
  );

  always_comb begin
    y_d    = dly_r[SIDE_DLY-1][DATA_WIDTH-1:0];
    sat_d  = dly_r[SIDE_DLY-1][DATA_WIDTH];
    last_d = dly_r[SIDE_DLY-1][DATA_WIDTH+1];
    yq_f   = YQ_W'(64'(y_d) <<< SH_Q);
    tmag   = tsat_d ? Q_W'(64'd1 << IQ) : q_d;
    onep   = neg_d ? (Q_W+1)'(64'd1 << IQ) - {1'b0, tmag}
                   : (Q_W+1)'(64'd1 << IQ) + {1'b0, tmag};
    prod   = yq_f * $signed({1'b0, onep});
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod;
    y_f_r    <= y_d;
    sat_f_r  <= sat_d;
    last_f_r <= last_d;
  end

  always_comb begin
    y64 = 64'(y_f_r);
    res = rnd_shr(64'(prod_r), FIN_SH);
    if (!gelu_en_r || y64 > LIM) begin
      sel = y64;
    end else if (y64 < -LIM) begin
      sel = 64'sd0;
    end else begin
      sel = res;
    end
    if (sel > MAXV) begin
      sel = MAXV;
    end else if (sel < MINV) begin
      sel = MINV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r     <= 1'b0;
      vld_f_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_e_r     <= ch_vld[TAYLOR_TERMS];
      vld_f_r     <= vld_d;
      out_valid_r <= vld_f_r;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= DATA_WIDTH'(sel);
    out_last_r  <= last_f_r;
    out_sat_r   <= sat_f_r;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_last      = out_last_r;
  assign out_saturated = out_sat_r;

  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT_TOTAL))
    else $error("result without a matching item");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[ADDR_W-1] == REG_IDX_GELU)
      |=> gelu_en_r == $past(pwdata[0]))
    else $error("gelu_enable write lost");

endmodule
`default_nettype wire

// File: design/bgelu_front.sv
`default_nettype none
module bgelu_front #(
  parameter int DATA_WIDTH = bgelu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = bgelu_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [DATA_WIDTH-1:0]      x_i,
  input  logic signed [DATA_WIDTH-1:0]      b_i,
  input  logic                              last_i,
  output logic signed [DATA_WIDTH-1:0]      y_o,
  output logic                              sat_o,
  output logic                              last_o,
  output logic                              vld_o,
  output logic [bgelu_pkg::R_W-1:0]         r_o,
  output bgelu_pkg::tside_t                 side_o
);
  import bgelu_pkg::*;

  localparam int SH_Q = IQ - FRAC_BITS;

  logic [LAT_FRONT-1:0] vld_r;

  logic signed [DATA_WIDTH-1:0] y_r, y_nxt;
  logic sat_r, last_r;
  logic [DATA_WIDTH:0] sum;
  logic ovf;

  logic signed [YQ_W-1:0] yq1, yq2_r, yq3_r;
  logic signed [2*YQ_W-1:0] prod2;
  logic signed [Y2_W-1:0] y2_r, y2_nxt;
  logic signed [Y2_W+YQ_W-1:0] prod3;
  logic signed [Y3_W-1:0] y3_r, y3_nxt;
  logic signed [Y3_W+22-1:0] prod4;
  logic signed [IN_W-1:0] inner_r, inner_nxt;
  logic signed [IN_W+25-1:0] prod5;
  logic signed [U_W-1:0] u_r, u_nxt, a;
  logic [V_W-1:0] v, v_r;
  logic [K_MAX-1:0] ge;
  tside_t side6_r, side6_nxt, side7_r;
  logic [R_W-1:0] r_r;

  always_comb begin
    sum = {x_i[DATA_WIDTH-1], x_i} + {b_i[DATA_WIDTH-1], b_i};
    ovf = sum[DATA_WIDTH] ^ sum[DATA_WIDTH-1];
    if (ovf) begin
      y_nxt = sum[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                              : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      y_nxt = sum[DATA_WIDTH-1:0];
    end
  end

  always_comb begin
    yq1       = YQ_W'(64'(y_r) <<< SH_Q);
    prod2     = yq1 * yq1;
    y2_nxt    = Y2_W'(rnd_shr(64'(prod2), IQ));
    prod3     = y2_r * yq2_r;
    y3_nxt    = Y3_W'(rnd_shr(64'(prod3), IQ));
    prod4     = C_CUBIC * y3_r;
    inner_nxt = IN_W'(64'(yq3_r) + rnd_shr(64'(prod4), IQ));
    prod5     = C_SQRT2PI * inner_r;
    u_nxt     = U_W'(rnd_shr(64'(prod5), IQ));
  end

  // tanh range reduction: 2|u| = k*ln2 + r
  always_comb begin
    a = u_r[U_W-1] ? -u_r : u_r;
    v = {a[A_W-1:0], 7'b0};
    for (int j = 0; j < K_MAX; j++) begin
      ge[j] = (v >= ln2_mul(K_W'(j + 1)));
    end
    side6_nxt.k    = K_W'($countones(ge));
    side6_nxt.neg  = u_r[U_W-1];
    side6_nxt.tsat = (u_r > U_SAT) || (u_r < -U_SAT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT_FRONT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    y_r     <= y_nxt;
    sat_r   <= ovf;
    last_r  <= last_i;
    yq2_r   <= yq1;
    y2_r    <= y2_nxt;
    yq3_r   <= yq2_r;
    y3_r    <= y3_nxt;
    inner_r <= inner_nxt;
    u_r     <= u_nxt;
    v_r     <= v;
    side6_r <= side6_nxt;
    r_r     <= R_W'(v_r - ln2_mul(side6_r.k));
    side7_r <= side6_r;
  end

  assign y_o    = y_r;
  assign sat_o  = sat_r;
  assign last_o = last_r;
  assign vld_o  = vld_r[LAT_FRONT-1];
  assign r_o    = r_r;
  assign side_o = side7_r;

endmodule
`default_nettype wire

// File: design/bgelu_exp_step.sv
`default_nettype none
module bgelu_exp_step #(
  parameter int N = bgelu_pkg::TAYLOR_TERMS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  logic [bgelu_pkg::R_W-1:0] r_i,
  input  logic [bgelu_pkg::P_W-1:0] p_i,
  input  bgelu_pkg::tside_t         side_i,
  output logic                      vld_o,
  output logic [bgelu_pkg::R_W-1:0] r_o,
  output logic [bgelu_pkg::P_W-1:0] p_o,
  output bgelu_pkg::tside_t         side_o
);
  import bgelu_pkg::*;

  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);

  logic [R_W+P_W-1:0] m;
  logic [P_W-1:0] t_nxt, t_a_r, t_b_r, qe_nxt, qe_b_r, p_nxt, p_c_r;
  logic [63:0] qprod;
  logic [33:0] rem;
  logic [P_W-1:0] q;
  logic [R_W-1:0] r_a_r, r_b_r, r_c_r;
  tside_t side_a_r, side_b_r, side_c_r;
  logic vld_a_r, vld_b_r, vld_c_r;

  always_comb begin
    m      = r_i * p_i;
    t_nxt  = P_W'((64'(m) + (64'd1 << (EQ - 1))) >> EQ);
    qprod  = 64'(t_a_r) * 64'(RECIP);
    qe_nxt = P_W'(qprod >> 32);
    // reciprocal estimate is low by at most one
    rem    = 34'(t_b_r) - 34'(qe_b_r) * 34'(N);
    q      = (rem >= 34'(N)) ? qe_b_r + P_W'(1) : qe_b_r;
    p_nxt  = ONE_P - q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else begin
      vld_a_r <= vld_i;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    t_a_r    <= t_nxt;
    r_a_r    <= r_i;
    side_a_r <= side_i;
    t_b_r    <= t_a_r;
    qe_b_r   <= qe_nxt;
    r_b_r    <= r_a_r;
    side_b_r <= side_a_r;
    p_c_r    <= p_nxt;
    r_c_r    <= r_b_r;
    side_c_r <= side_b_r;
  end

  assign vld_o  = vld_c_r;
  assign r_o    = r_c_r;
  assign p_o    = p_c_r;
  assign side_o = side_c_r;

  a_p_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c_r |-> p_c_r <= ONE_P)
    else $error("series term above one");

endmodule
`default_nettype wire

// File: design/bgelu_div.sv
`default_nettype none
module bgelu_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  input  logic [bgelu_pkg::DVD_W-1:0] dvd_i,
  input  logic [bgelu_pkg::DEN_W-1:0] den_i,
  input  logic                        neg_i,
  input  logic                        tsat_i,
  output logic                        vld_o,
  output logic [bgelu_pkg::Q_W-1:0]   q_o,
  output logic                        neg_o,
  output logic                        tsat_o
);
  import bgelu_pkg::*;

  logic [DEN_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   lo_r  [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [1:0]       flg_r [Q_W];
  logic [Q_W-1:0]   vld_r;

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [DEN_W-1:0] rem_in, den_in;
    logic [Q_W-1:0]   lo_in, q_in;
    logic [1:0]       flg_in;
    logic             vld_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (j == 0) begin : g_head
      assign rem_in = DEN_W'(dvd_i >> Q_W);
      assign lo_in  = dvd_i[Q_W-1:0];
      assign q_in   = '0;
      assign den_in = den_i;
      assign flg_in = {neg_i, tsat_i};
      assign vld_in = vld_i;
    end else begin : g_body
      assign rem_in = rem_r[j-1];
      assign lo_in  = lo_r[j-1];
      assign q_in   = q_r[j-1];
      assign den_in = den_r[j-1];
      assign flg_in = flg_r[j-1];
      assign vld_in = vld_r[j-1];
    end

    assign trial = {rem_in, lo_in[Q_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_r[j] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
      lo_r[j]  <= lo_in << 1;
      q_r[j]   <= {q_in[Q_W-2:0], ge};
      den_r[j] <= den_in;
      flg_r[j] <= flg_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_in;
      end
    end
  end

  assign vld_o  = vld_r[Q_W-1];
  assign q_o    = q_r[Q_W-1];
  assign neg_o  = flg_r[Q_W-1][1];
  assign tsat_o = flg_r[Q_W-1][0];

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_o |-> q_o <= Q_W'(64'd1 << IQ))
    else $error("tanh quotient above one");

endmodule
`default_nettype wire

// File: tb/bias_add_gelu_activation_test.sv
`default_nettype none
module bias_add_gelu_activation_test;
  import bgelu_pkg::*;

  localparam int W = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam logic [2:0] ADDR_GELU_ENABLE = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam int DRAIN_CYCLES = LAT_TOTAL + 20;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [W-1:0] value;
    logic         last;
    logic         saturated;
  } gelu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [W-1:0] in_value = '0;
  logic signed [W-1:0] in_bias = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic signed [W-1:0] out_value;
  logic out_last;
  logic out_saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gelu_result_t expected_q[$];
  logic gelu_on;
  int mismatch_count = 0;
  int idle_pct = 0;
  longint cycle_count = 0;

  bias_add_gelu_activation uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_value(in_value), .in_bias(in_bias), .in_last(in_last),
    .out_valid(out_valid), .out_value(out_value), .out_last(out_last),
    .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bias_add_gelu_activation: mismatch");
      $finish;
    end
  end

  function automatic longint shr_round_up(longint v, int s);
    longint w;
    w = v + (64'sd1 <<< (s - 1));
    if (w >= 0) return longint'(longint'(unsigned'(w)) >>> s);
    return -longint'((longint'(-w) + ((64'sd1 <<< s) - 1)) >>> s);
  endfunction

  function automatic longint exp_neg(longint r);
    longint one, p, t;
    one = 64'sd1 <<< EQ;
    p = one;
    for (int n = TAYLOR_TERMS; n >= 1; n--) begin
      t = (r * p + (one >>> 1)) >>> EQ;
      p = one - t / n;
    end
    return p;
  endfunction

  function automatic longint tanh_fixed(longint u);
    longint one24, one30, a, v, k, r, e, num, den, t;
    one24 = 64'sd1 <<< IQ;
    one30 = 64'sd1 <<< EQ;
    if (u > 8 * one24) return one24;
    if (u < -8 * one24) return -one24;
    a = (u < 0) ? -u : u;
    v = a <<< (EQ - IQ + 1);
    k = v / longint'(LN2_Q30);
    r = v - k * longint'(LN2_Q30);
    e = exp_neg(r) >>> (k & 63);
    num = one30 - e;
    den = one30 + e;
    t = ((num <<< IQ) + (den >>> 1)) / den;
    return (u < 0) ? -t : t;
  endfunction

  function automatic longint gelu_of(longint y);
    longint lim, yq, y2, y3, inner, u, t;
    lim = 64'sd8 <<< FB;
    if (y > lim) return y;
    if (y < -lim) return 0;
    yq = y * (64'sd1 <<< (IQ - FB));
    y2 = shr_round_up(yq * yq, IQ);
    y3 = shr_round_up(y2 * yq, IQ);
    inner = yq + shr_round_up(750193 * y3, IQ);
    u = shr_round_up(13386282 * inner, IQ);
    t = tanh_fixed(u);
    return shr_round_up(yq * ((64'sd1 <<< IQ) + t), IQ + 1 + IQ - FB);
  endfunction

  function automatic gelu_result_t predict_activation(logic signed [W-1:0] x,
                                                      logic signed [W-1:0] b,
                                                      logic last);
    gelu_result_t res;
    longint maxv, minv, y, r;
    maxv = (64'sd1 <<< (W - 1)) - 1;
    minv = -maxv - 1;
    y = longint'(x) + longint'(b);
    res.saturated = 1'b0;
    if (y > maxv) begin
      y = maxv;
      res.saturated = 1'b1;
    end else if (y < minv) begin
      y = minv;
      res.saturated = 1'b1;
    end
    r = gelu_on ? gelu_of(y) : y;
    if (r > maxv) r = maxv;
    if (r < minv) r = minv;
    res.value = r[W-1:0];
    res.last = last;
    return res;
  endfunction

  always @(posedge clk) begin
    gelu_result_t got, want;
    if (rst_n && out_valid) begin
      got = '{value: out_value, last: out_last, saturated: out_saturated};
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item: value=%0d last=%0b sat=%0b",
                   out_value, out_last, out_saturated);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("item differs: want value=%0d last=%0b sat=%0b, got %0d %0b %0b",
                     $signed(want.value), want.last, want.saturated,
                     out_value, out_last, out_saturated);
        end
      end
    end
  end

  task automatic send_item(logic signed [W-1:0] x, logic signed [W-1:0] b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_value <= x;
    in_bias <= b;
    in_last <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_activation(x, b, last));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_GELU_ENABLE) gelu_on = data[0];
  endtask

  function automatic logic signed [W-1:0] rand_field();
    case ($urandom_range(5))
      0: return W'($urandom);
      1: return W'($signed($urandom_range(1048576)) - 524288);
      2: return W'($signed($urandom_range(131072)) - 65536);
      3: return ($urandom_range(1)) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
      default: return W'($signed($urandom_range(1200000)) - 600000);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [W-1:0] maxc, minc;
    maxc = {1'b0, {(W-1){1'b1}}};
    minc = {1'b1, {(W-1){1'b0}}};
    send_item(24'sd0, 24'sd0, 1'b0);
    send_item(maxc, 24'sd0, 1'b1);
    send_item(minc, 24'sd0, 1'b0);
    send_item(maxc, maxc, 1'b1);
    send_item(minc, minc, 1'b0);
    send_item(maxc, 24'sd1, 1'b0);
    send_item(minc, -24'sd1, 1'b1);
    send_item(24'sd524288, 24'sd1, 1'b0);
    send_item(24'sd524288, 24'sd0, 1'b0);
    send_item(-24'sd524288, -24'sd1, 1'b1);
    send_item(-24'sd524288, 24'sd0, 1'b0);
    send_item(24'sd65536, 24'sd0, 1'b0);
    send_item(-24'sd65536, 24'sd0, 1'b0);
    send_item(24'sd1, 24'sd0, 1'b1);
    send_item(-24'sd1, 24'sd0, 1'b0);
    send_item(24'sd300000, -24'sd20000, 1'b0);
    send_item(-24'sd300000, 24'sd1000, 1'b1);
    send_item(24'sd40000, 24'sd3, 1'b0);
    wait_drained();
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++)
      send_item(rand_field(), rand_field(), 1'($urandom_range(1)));
    idle_pct = 0;
  endtask

  task automatic test_modes();
    // bypass mode, then an ignored write to a non-existent register
    write_reg(ADDR_GELU_ENABLE, 32'h0000_0000);
    test_directed();
    test_random(150, 54);
    wait_drained();
    write_reg(ADDR_UNUSED, 32'hffff_ffff);
    test_random(50, 0);
    wait_drained();
    // only bit 0 counts
    write_reg(ADDR_GELU_ENABLE, 32'hffff_fffe);
    test_random(50, 9);
    wait_drained();
    write_reg(ADDR_GELU_ENABLE, 32'hffff_ffff);
  endtask

  initial begin
    gelu_on = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400, 0);
    test_random(400, 54);
    wait_drained();
    test_modes();
    test_random(300, 9);
    test_random(100, 0);
    wait_drained();
    if (mismatch_count == 0)
      $display("bias_add_gelu_activation: match");
    else
      $display("bias_add_gelu_activation: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

// File: bias_add_gelu_activation.f
design/bgelu_pkg.sv
design/bgelu_front.sv
design/bgelu_exp_step.sv
design/bgelu_div.sv
design/bias_add_gelu_activation.sv
tb/bias_add_gelu_activation_test.sv
